/* design/cfcc_pkg.sv */
// ----------------------------------------------------------------------------
// cfcc_pkg
// Shared types, constants and helpers for the colour frame calibrate and
// classify block.
// ----------------------------------------------------------------------------
`default_nettype none

package cfcc_pkg;

  // Frame layout
  localparam int unsigned DIGITS_PER_CHANNEL = 3;
  localparam int unsigned FRAME_DIGITS       = 3 * DIGITS_PER_CHANNEL;
  localparam int unsigned CHAN_BITS          = 4 * DIGITS_PER_CHANNEL;
  localparam int unsigned ACC_W              = 4 * FRAME_DIGITS;
  localparam int unsigned POS_W              = $clog2(FRAME_DIGITS + 1);

  // Channel and level widths
  localparam int unsigned RAW_W  = 12;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned STEP_W = $clog2(LVL_W);
  // Remainder holds 510*n + d, n and d below 2^RAW_W
  localparam int unsigned REM_W  = RAW_W + LVL_W + 2;
  // Divisor 2*d aligned to the top quotient bit
  localparam int unsigned DVS_W  = RAW_W + LVL_W;

  localparam logic [RAW_W-1:0] RAW_MAX = '1;
  localparam logic [LVL_W-1:0] LVL_MAX = '1;

  // Start-of-frame character '$'
  localparam logic [7:0] START_CHAR = 8'h24;

  typedef enum logic [1:0] {
    MODE_CORRECT = 2'd0,
    MODE_BLACK   = 2'd1,
    MODE_WHITE   = 2'd2,
    MODE_RAW     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_RED   = 2'd1,
    CLASS_GREEN = 2'd2,
    CLASS_BLUE  = 2'd3
  } class_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ASCII hex digit decode
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* design/colour_frame_calibrate_classify.sv */
// ----------------------------------------------------------------------------
// colour_frame_calibrate_classify
// Parses '$'-framed hex colour triples and captures black/white references;
// in correct mode it scales channels to 0..255 (bit-serial divider), classifies.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+---------------------
//  in      | in_valid_i, in_stall_o, rx_byte_i | in        | one character
//  out     | out_valid_o, out_stall_i, fields  | out       | one parsed frame
//  cfg     | cfg_valid_i, cfg_ready_o, data    | in        | capture_mode write
//
//  A frame finished in a capture mode or raw mode is loaded straight into the
//  output register. A frame in correct mode visits, per channel, ST_LOAD for
//  setup and ST_DIV for one step per quotient bit of the shared restoring
//  divider (no ST_DIV when a channel saturates or is invalid), then ST_FINISH.
//  Reset restores the references to black 0 / white full scale and mode 0.
//  Input stalls outside ST_IDLE or while a result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module colour_frame_calibrate_classify import cfcc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // character input
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       rx_byte_i,
  // result output
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [RAW_W-1:0]      raw_red_o,
  output logic [RAW_W-1:0]      raw_green_o,
  output logic [RAW_W-1:0]      raw_blue_o,
  output logic [LVL_W-1:0]      level_red_o,
  output logic [LVL_W-1:0]      level_green_o,
  output logic [LVL_W-1:0]      level_blue_o,
  output logic [1:0]            colour_class_o,
  output logic                  reference_bad_o,
  // configuration
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [1:0]       cfg_data_i
);

  state_e             state_q, state_d;
  mode_e              mode_q;
  logic [POS_W-1:0]   pos_q;
  logic [ACC_W-1:0]   acc_q;
  logic [RAW_W-1:0]   black_q [3];
  logic [RAW_W-1:0]   white_q [3];
  logic [RAW_W-1:0]   chan_raw_q [3];
  logic [LVL_W-1:0]   lvl_q [3];
  logic [1:0]         ch_q;
  logic [STEP_W-1:0]  step_q;
  logic [REM_W-1:0]   rem_q;
  logic [DVS_W-1:0]   dvs_q;
  logic [LVL_W-1:0]   quot_q;
  logic               bad_q;

  logic               out_valid_q;
  logic [RAW_W-1:0]   out_raw_q [3];
  logic [LVL_W-1:0]   out_lvl_q [3];
  class_e             out_class_q;
  logic               out_bad_q;

  // Handshakes
  logic in_fire, out_free;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Character parse
  hex_t             hex;
  logic [ACC_W-1:0] acc_next;
  logic             frame_done;
  logic [RAW_W-1:0] frame_raw [3];

  assign hex        = hex_decode(rx_byte_i);
  assign acc_next   = {acc_q[ACC_W-5:0], hex.val};
  assign frame_done = in_fire && (pos_q != '0) && hex.ok
                      && (pos_q == POS_W'(FRAME_DIGITS));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      frame_raw[i] = RAW_W'(acc_next[CHAN_BITS*(2-i) +: CHAN_BITS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      if (pos_q == '0) begin
        if (rx_byte_i == START_CHAR) pos_q <= POS_W'(1);
      end else if (!hex.ok || frame_done) begin
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (pos_q == '0) begin
        acc_q <= '0;
      end else if (hex.ok) begin
        acc_q <= acc_next;
      end
    end
  end

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CORRECT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // Reference capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        black_q[i] <= '0;
        white_q[i] <= RAW_MAX;
      end
    end else if (frame_done) begin
      for (int i = 0; i < 3; i++) begin
        if (mode_q == MODE_BLACK) black_q[i] <= frame_raw[i];
        if (mode_q == MODE_WHITE) white_q[i] <= frame_raw[i];
      end
    end
  end

  // Per-channel operands of the current divider pass
  logic [RAW_W-1:0] cur_raw, cur_blk, cur_wht, num, den;
  logic [REM_W-1:0] rem_init;
  logic [REM_W-1:0] dvs_ext;
  logic             take_bit;
  logic [LVL_W-1:0] quot_next;

  assign cur_raw   = chan_raw_q[ch_q];
  assign cur_blk   = black_q[ch_q];
  assign cur_wht   = white_q[ch_q];
  assign num       = cur_raw - cur_blk;
  assign den       = cur_wht - cur_blk;
  // 510*num + den
  assign rem_init  = (REM_W'(num) << 9) - (REM_W'(num) << 1) + REM_W'(den);
  assign dvs_ext   = REM_W'(dvs_q);
  assign take_bit  = rem_q >= dvs_ext;
  assign quot_next = {quot_q[LVL_W-2:0], take_bit};

  // Classification over finished levels
  logic [LVL_W:0] sum_gb, sum_rb, sum_rg;
  class_e         cls;
  assign sum_gb = {1'b0, lvl_q[1]} + {1'b0, lvl_q[2]};
  assign sum_rb = {1'b0, lvl_q[0]} + {1'b0, lvl_q[2]};
  assign sum_rg = {1'b0, lvl_q[0]} + {1'b0, lvl_q[1]};

  always_comb begin
    priority if ({1'b0, lvl_q[0]} > sum_gb) cls = CLASS_RED;
    else if ({1'b0, lvl_q[1]} > sum_rb)     cls = CLASS_GREEN;
    else if ({1'b0, lvl_q[2]} > sum_rg)     cls = CLASS_BLUE;
    else                                    cls = CLASS_NONE;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (frame_done && mode_q == MODE_CORRECT) state_d = ST_LOAD;
      ST_LOAD: begin
        if (cur_wht > cur_blk && cur_raw > cur_blk && cur_raw < cur_wht) begin
          state_d = ST_DIV;
        end else if (ch_q == 2'd2) begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (step_q == '0) state_d = (ch_q == 2'd2) ? ST_FINISH : ST_LOAD;
      end
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE:   ch_q <= '0;
        ST_LOAD: begin
          step_q <= STEP_W'(LVL_W - 1);
          if (state_d != ST_DIV && ch_q != 2'd2) ch_q <= ch_q + 2'd1;
        end
        ST_DIV: begin
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0 && ch_q != 2'd2) ch_q <= ch_q + 2'd1;
        end
        ST_FINISH: ch_q <= '0;
        default:   ch_q <= '0;
      endcase
    end
  end

  // Datapath: one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      for (int i = 0; i < 3; i++) chan_raw_q[i] <= frame_raw[i];
      bad_q <= 1'b0;
    end
    unique case (state_q)
      ST_LOAD: begin
        quot_q <= '0;
        rem_q  <= rem_init;
        dvs_q  <= DVS_W'(den) << LVL_W;
        if (cur_wht <= cur_blk) begin
          lvl_q[ch_q] <= '0;
          bad_q       <= 1'b1;
        end else if (cur_raw <= cur_blk) begin
          lvl_q[ch_q] <= '0;
        end else if (cur_raw >= cur_wht) begin
          lvl_q[ch_q] <= LVL_MAX;
        end
      end
      ST_DIV: begin
        if (take_bit) rem_q <= rem_q - dvs_ext;
        dvs_q  <= dvs_q >> 1;
        quot_q <= quot_next;
        if (step_q == '0) lvl_q[ch_q] <= quot_next;
      end
      default: ;
    endcase
  end

  // Output register
  logic load_direct, load_finish;
  assign load_direct = frame_done && mode_q != MODE_CORRECT;
  assign load_finish = state_q == ST_FINISH && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_direct || load_finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_direct) begin
      for (int i = 0; i < 3; i++) begin
        out_raw_q[i] <= frame_raw[i];
        out_lvl_q[i] <= '0;
      end
      out_class_q <= CLASS_NONE;
      out_bad_q   <= 1'b0;
    end else if (load_finish) begin
      for (int i = 0; i < 3; i++) begin
        out_raw_q[i] <= chan_raw_q[i];
        out_lvl_q[i] <= lvl_q[i];
      end
      out_class_q <= cls;
      out_bad_q   <= bad_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign raw_red_o       = out_raw_q[0];
  assign raw_green_o     = out_raw_q[1];
  assign raw_blue_o      = out_raw_q[2];
  assign level_red_o     = out_lvl_q[0];
  assign level_green_o   = out_lvl_q[1];
  assign level_blue_o    = out_lvl_q[2];
  assign colour_class_o  = out_class_q;
  assign reference_bad_o = out_bad_q;

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(FRAME_DIGITS))
    else $error("frame position past last digit");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < (dvs_ext << 1))
    else $error("divider remainder out of bound, quotient overflow");

  a_class_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && colour_class_o == CLASS_RED
      |-> {1'b0, level_red_o} > ({1'b0, level_green_o} + {1'b0, level_blue_o}))
    else $error("red class without red dominance");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reference_bad_o
      |-> (level_red_o == '0 || level_green_o == '0 || level_blue_o == '0))
    else $error("bad reference reported but no channel reads zero");

endmodule

`default_nettype wire
